// File: rtl/cpr_pkg.sv
package cpr_pkg;

  localparam int FRAME_SLOTS = 64;

  localparam int CMD_W      = 2;
  localparam int SLOT_FLD_W = 6;
  localparam int FIU_W      = 7;

  localparam int ADDR_W  = (FRAME_SLOTS > 1) ? $clog2(FRAME_SLOTS) : 1;
  localparam int COUNT_W = $clog2(FRAME_SLOTS + 1);
  localparam int EXT_W   = ADDR_W + SLOT_FLD_W + 1;

  typedef logic [CMD_W-1:0]      cmd_fld_t;
  typedef logic [SLOT_FLD_W-1:0] slot_fld_t;
  typedef logic [FIU_W-1:0]      fiu_t;
  typedef logic [ADDR_W-1:0]     addr_t;
  typedef logic [COUNT_W-1:0]    count_t;
  typedef logic [EXT_W-1:0]      ext_t;

  typedef enum logic [CMD_W-1:0] {
    CMD_TOUCH  = 2'd0,
    CMD_ADD    = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_SELECT = 2'd3
  } cmd_t;

  typedef struct packed {
    logic valid;
    logic accessed;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam addr_t LAST_SLOT = addr_t'(FRAME_SLOTS - 1);

  function automatic addr_t hand_advance(input addr_t h);
    hand_advance = (h == LAST_SLOT) ? '0 : h + 1'b1;
  endfunction

endpackage

// File: rtl/cpr_in_if.sv
interface cpr_in_if;
  logic                 valid;
  logic                 ready;
  cpr_pkg::cmd_fld_t    cmd;
  cpr_pkg::slot_fld_t   frame_slot;

  modport source (output valid, output cmd, output frame_slot, input ready);
  modport sink (input valid, input cmd, input frame_slot, output ready);
endinterface

// File: rtl/cpr_out_if.sv
interface cpr_out_if;
  logic                 valid;
  logic                 ready;
  cpr_pkg::slot_fld_t   victim_slot;
  logic                 victim_found;
  cpr_pkg::fiu_t        frames_in_use;

  modport source (output valid, output victim_slot, output victim_found,
                  output frames_in_use, input ready);
  modport sink (input valid, input victim_slot, input victim_found,
                input frames_in_use, output ready);
endinterface

// File: rtl/cpr_ram.sv
module cpr_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 64
) (
  input  logic                                       clk,
  input  logic                                       we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                           wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/clock_page_replacement_core.sv
// Second-chance clock victim selector over FRAME_SLOTS frame slots. The valid and
// accessed bits of all slots live in one synchronous RAM, so after reset the block
// clears it one slot at a time and accepts no request until that is done.
// Touch, add and remove do one read-modify-write of their slot. A select walks the
// ring one slot per cycle through the RAM read port, clearing set accessed bits as
// it passes, and goes straight to the result when no frame is valid. The result
// waits in an output register, and a new request is taken once that result has
// been loaded into it.
module clock_page_replacement_core (
  input  logic            clk,
  input  logic            rst_n,
  cpr_in_if.sink          in_req,
  cpr_out_if.source       out_res
);

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RMW,
    ST_SWEEP,
    ST_RESULT
  } state_t;

  state_t              state_r, state_nxt;
  cpr_pkg::addr_t      clr_r, clr_nxt;
  cpr_pkg::addr_t      hand_r, hand_nxt;
  cpr_pkg::addr_t      scan_r, scan_nxt;
  cpr_pkg::count_t     count_r, count_nxt;
  cpr_pkg::cmd_t       cmd_r, cmd_nxt;
  cpr_pkg::addr_t      addr_r, addr_nxt;
  logic                in_range_r, in_range_nxt;
  cpr_pkg::addr_t      res_victim_r, res_victim_nxt;
  logic                res_found_r, res_found_nxt;
  logic                out_valid_r, out_valid_nxt;
  cpr_pkg::slot_fld_t  out_victim_r, out_victim_nxt;
  logic                out_found_r, out_found_nxt;
  cpr_pkg::fiu_t       out_fiu_r, out_fiu_nxt;

  logic                ram_we;
  cpr_pkg::addr_t      ram_waddr;
  cpr_pkg::entry_t     ram_wdata;
  cpr_pkg::addr_t      ram_raddr;
  cpr_pkg::entry_t     ram_rdata;

  cpr_pkg::ext_t       in_slot_ext;
  cpr_pkg::addr_t      next_scan;

  cpr_ram #(
    .WIDTH (cpr_pkg::ENTRY_W),
    .DEPTH (cpr_pkg::FRAME_SLOTS)
  ) u_slot_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_req.ready          = (state_r == ST_IDLE);
  assign out_res.valid         = out_valid_r;
  assign out_res.victim_slot   = out_victim_r;
  assign out_res.victim_found  = out_found_r;
  assign out_res.frames_in_use = out_fiu_r;

  assign in_slot_ext = cpr_pkg::ext_t'(in_req.frame_slot);
  assign next_scan   = cpr_pkg::hand_advance(scan_r);

  always_comb begin
    state_nxt      = state_r;
    clr_nxt        = clr_r;
    hand_nxt       = hand_r;
    scan_nxt       = scan_r;
    count_nxt      = count_r;
    cmd_nxt        = cmd_r;
    addr_nxt       = addr_r;
    in_range_nxt   = in_range_r;
    res_victim_nxt = res_victim_r;
    res_found_nxt  = res_found_r;
    out_valid_nxt  = out_valid_r & ~out_res.ready;
    out_victim_nxt = out_victim_r;
    out_found_nxt  = out_found_r;
    out_fiu_nxt    = out_fiu_r;

    ram_we         = 1'b0;
    ram_waddr      = addr_r;
    ram_wdata      = '0;
    ram_raddr      = cpr_pkg::addr_t'(in_slot_ext);

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == cpr_pkg::LAST_SLOT) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_req.valid) begin
          cmd_nxt        = cpr_pkg::cmd_t'(in_req.cmd);
          addr_nxt       = cpr_pkg::addr_t'(in_slot_ext);
          in_range_nxt   = (in_slot_ext < cpr_pkg::ext_t'(cpr_pkg::FRAME_SLOTS));
          res_victim_nxt = '0;
          res_found_nxt  = 1'b0;
          if (cpr_pkg::cmd_t'(in_req.cmd) == cpr_pkg::CMD_SELECT) begin
            if (count_r == '0) begin
              state_nxt = ST_RESULT;
            end else begin
              ram_raddr = hand_r;
              scan_nxt  = hand_r;
              state_nxt = ST_SWEEP;
            end
          end else begin
            state_nxt = ST_RMW;
          end
        end
      end

      ST_RMW: begin
        if (in_range_r) begin
          case (cmd_r)
            cpr_pkg::CMD_TOUCH: begin
              if (ram_rdata.valid) begin
                ram_we    = 1'b1;
                ram_wdata = '{valid: 1'b1, accessed: 1'b1};
              end
            end
            cpr_pkg::CMD_ADD: begin
              ram_we    = 1'b1;
              ram_wdata = '{valid: 1'b1, accessed: 1'b0};
              if (!ram_rdata.valid) begin
                count_nxt = count_r + 1'b1;
              end
            end
            cpr_pkg::CMD_REMOVE: begin
              if (ram_rdata.valid) begin
                ram_we    = 1'b1;
                count_nxt = count_r - 1'b1;
              end
            end
            default: begin
            end
          endcase
        end
        state_nxt = ST_RESULT;
      end

      ST_SWEEP: begin
        if (ram_rdata.valid && !ram_rdata.accessed) begin
          res_victim_nxt = scan_r;
          res_found_nxt  = 1'b1;
          hand_nxt       = next_scan;
          state_nxt      = ST_RESULT;
        end else begin
          if (ram_rdata.valid) begin
            ram_we    = 1'b1;
            ram_waddr = scan_r;
            ram_wdata = '{valid: 1'b1, accessed: 1'b0};
          end
          scan_nxt  = next_scan;
          ram_raddr = next_scan;
        end
      end

      ST_RESULT: begin
        if (!out_valid_r || out_res.ready) begin
          out_valid_nxt  = 1'b1;
          out_victim_nxt = cpr_pkg::slot_fld_t'(cpr_pkg::ext_t'(res_victim_r));
          out_found_nxt  = res_found_r;
          out_fiu_nxt    = cpr_pkg::fiu_t'(count_r);
          state_nxt      = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      hand_r      <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      hand_r      <= hand_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    scan_r       <= scan_nxt;
    cmd_r        <= cmd_nxt;
    addr_r       <= addr_nxt;
    in_range_r   <= in_range_nxt;
    res_victim_r <= res_victim_nxt;
    res_found_r  <= res_found_nxt;
    out_victim_r <= out_victim_nxt;
    out_found_r  <= out_found_nxt;
    out_fiu_r    <= out_fiu_nxt;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= cpr_pkg::count_t'(cpr_pkg::FRAME_SLOTS))
    else $error("valid frame count exceeds the number of slots");

  a_hand_bound: assert property (@(posedge clk) disable iff (!rst_n)
    hand_r <= cpr_pkg::LAST_SLOT)
    else $error("clock hand outside the slot range");

  a_sweep_has_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SWEEP) |-> (count_r != '0))
    else $error("victim sweep running with no valid frames");

  a_found_needs_frames: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_found_r) |-> (out_fiu_r != '0))
    else $error("victim reported while no frame is in use");

  a_no_victim_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_found_r) |-> (out_victim_r == '0))
    else $error("nonzero victim slot without a victim");

  a_clear_no_request: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |=> (out_valid_r == 1'b0))
    else $error("result produced during the RAM clearing pass");

endmodule

// File: test/clock_page_replacement_core_test.sv
module clock_page_replacement_core_test;

  typedef struct {
    cpr_pkg::cmd_t      op;
    cpr_pkg::slot_fld_t slot;
    int                 gap;
    bit                 drain;
  } request_t;

  typedef struct packed {
    cpr_pkg::slot_fld_t victim_slot;
    logic               victim_found;
    cpr_pkg::fiu_t      frames_in_use;
  } outcome_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  cpr_in_if  in_ch ();
  cpr_out_if out_ch ();

  clock_page_replacement_core u_top (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_req  (in_ch),
    .out_res (out_ch)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  request_t    request_q[$];
  outcome_t    outcome_q[$];
  bit          frame_live[cpr_pkg::FRAME_SLOTS];
  bit          frame_ref[cpr_pkg::FRAME_SLOTS];
  int unsigned hand_pos;
  int unsigned live_count;
  int          mismatch_count;
  int          results_seen;
  bit          sender_calm;
  bit          in_taken;
  bit          out_taken;
  bit          staged;
  request_t    cur_req;
  int          gap_left;
  int          stall_left;

  // Applies each request to the testbench's own copy of the frame table, with a second-chance sweep for a select.
  function automatic outcome_t frame_outcome(cpr_pkg::cmd_t op, cpr_pkg::slot_fld_t slot);
    outcome_t    r;
    int unsigned idx;
    int unsigned h;
    bit          hit;
    r = '0;
    idx = slot;
    hit = 1'b0;
    case (op)
      cpr_pkg::CMD_TOUCH: begin
        if (idx < cpr_pkg::FRAME_SLOTS && frame_live[idx]) frame_ref[idx] = 1'b1;
      end
      cpr_pkg::CMD_ADD: begin
        if (idx < cpr_pkg::FRAME_SLOTS) begin
          if (!frame_live[idx]) begin
            frame_live[idx] = 1'b1;
            live_count++;
          end
          frame_ref[idx] = 1'b0;
        end
      end
      cpr_pkg::CMD_REMOVE: begin
        if (idx < cpr_pkg::FRAME_SLOTS && frame_live[idx]) begin
          frame_live[idx] = 1'b0;
          frame_ref[idx] = 1'b0;
          live_count--;
        end
      end
      default: begin
        if (live_count != 0) begin
          h = hand_pos;
          for (int n = 0; n < 2 * cpr_pkg::FRAME_SLOTS && !hit; n++) begin
            if (frame_live[h]) begin
              if (!frame_ref[h]) begin
                hit = 1'b1;
                r.victim_slot = cpr_pkg::slot_fld_t'(h);
                r.victim_found = 1'b1;
              end else begin
                frame_ref[h] = 1'b0;
              end
            end
            if (!hit) h = (h + 1) % cpr_pkg::FRAME_SLOTS;
          end
          hand_pos = hit ? (h + 1) % cpr_pkg::FRAME_SLOTS : h;
        end
      end
    endcase
    r.frames_in_use = cpr_pkg::fiu_t'(live_count);
    return r;
  endfunction

  task automatic queue_request(cpr_pkg::cmd_t op, int slot, bit drain);
    request_t rq;
    rq.op = op;
    rq.slot = cpr_pkg::slot_fld_t'(slot);
    rq.gap = sender_calm ? 0 : $urandom_range(0, 8);
    rq.drain = drain;
    request_q.push_back(rq);
  endtask

  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      staged = 1'b0;
      gap_left = 0;
    end else if (!(in_ch.valid && !in_taken)) begin
      if (!staged && request_q.size() != 0) begin
        cur_req = request_q.pop_front();
        staged = 1'b1;
        gap_left = cur_req.gap;
      end
      if (staged && gap_left == 0 && !(cur_req.drain && outcome_q.size() != 0)) begin
        in_ch.valid <= 1'b1;
        in_ch.cmd <= cur_req.op;
        in_ch.frame_slot <= cur_req.slot;
        staged = 1'b0;
      end else begin
        in_ch.valid <= 1'b0;
        if (staged && gap_left > 0) gap_left--;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_taken) stall_left = ((results_seen / 40) % 4 == 3) ? 0 : $urandom_range(0, 8);
      if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    outcome_t want;
    in_taken <= rst_n && in_ch.valid && in_ch.ready;
    out_taken <= rst_n && out_ch.valid && out_ch.ready;
    if (rst_n && in_ch.valid && in_ch.ready)
      outcome_q.push_back(frame_outcome(cpr_pkg::cmd_t'(in_ch.cmd), in_ch.frame_slot));
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (outcome_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("Unexpected result: slot %0d found %0d in use %0d",
                   out_ch.victim_slot, out_ch.victim_found, out_ch.frames_in_use);
      end else begin
        want = outcome_q.pop_front();
        if (out_ch.victim_slot !== want.victim_slot
            || out_ch.victim_found !== want.victim_found
            || out_ch.frames_in_use !== want.frames_in_use) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("Mismatch: expected slot %0d found %0d in use %0d, got %0d %0d %0d",
                     want.victim_slot, want.victim_found, want.frames_in_use,
                     out_ch.victim_slot, out_ch.victim_found, out_ch.frames_in_use);
        end
      end
    end
  end

  initial begin
    int base;
    int span;
    int pick;
    int rem_pct;
    cpr_pkg::cmd_t op;
    in_ch.valid = 1'b0;
    in_ch.cmd = '0;
    in_ch.frame_slot = '0;
    out_ch.ready = 1'b0;
    sender_calm = 1'b0;

    queue_request(cpr_pkg::CMD_SELECT, 0, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 63, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 42, 1'b0);
    queue_request(cpr_pkg::CMD_ADD, 0, 1'b0);
    queue_request(cpr_pkg::CMD_ADD, 63, 1'b0);
    queue_request(cpr_pkg::CMD_ADD, 0, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 63, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 0, 1'b0);
    queue_request(cpr_pkg::CMD_SELECT, 21, 1'b0);
    queue_request(cpr_pkg::CMD_SELECT, 63, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 0, 1'b0);
    queue_request(cpr_pkg::CMD_ADD, 42, 1'b0);
    queue_request(cpr_pkg::CMD_SELECT, 42, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 21, 1'b0);
    queue_request(cpr_pkg::CMD_ADD, 21, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 21, 1'b0);
    queue_request(cpr_pkg::CMD_TOUCH, 42, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 63, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 63, 1'b0);
    queue_request(cpr_pkg::CMD_SELECT, 0, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 0, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 21, 1'b0);
    queue_request(cpr_pkg::CMD_REMOVE, 42, 1'b0);
    queue_request(cpr_pkg::CMD_SELECT, 63, 1'b0);

    for (int p = 0; p < 7; p++) begin
      sender_calm = (p % 4 == 2);
      base = $urandom_range(0, 63);
      span = (p % 3 == 0) ? 63 : $urandom_range(3, 15);
      rem_pct = (p == 5) ? 45 : 15;
      for (int i = 0; i < 50; i++) begin
        pick = $urandom_range(0, 99);
        if (pick < 35) op = cpr_pkg::CMD_TOUCH;
        else if (pick < 60) op = cpr_pkg::CMD_ADD;
        else if (pick < 60 + rem_pct) op = cpr_pkg::CMD_REMOVE;
        else op = cpr_pkg::CMD_SELECT;
        queue_request(op, (base + $urandom_range(0, span)) % 64, i == 0);
      end
      // Fill every slot and mark each one accessed so that one search goes once round the whole ring.
      if (p == 3) begin
        for (int s = 0; s < 64; s++) queue_request(cpr_pkg::CMD_ADD, s, s == 0);
        for (int s = 0; s < 64; s++) queue_request(cpr_pkg::CMD_TOUCH, s, 1'b0);
        queue_request(cpr_pkg::CMD_SELECT, $urandom_range(0, 63), 1'b0);
        queue_request(cpr_pkg::CMD_SELECT, $urandom_range(0, 63), 1'b0);
      end
    end

    repeat (2) @(negedge clk);
    rst_n <= 1'b1;

    while (request_q.size() != 0 || staged || in_ch.valid) @(posedge clk);
    while (outcome_q.size() != 0) @(posedge clk);
    repeat (2 * cpr_pkg::FRAME_SLOTS + 8) @(posedge clk);
    if (mismatch_count == 0 && outcome_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

// File: clock_page_replacement_core.f
rtl/cpr_pkg.sv
rtl/cpr_in_if.sv
rtl/cpr_out_if.sv
rtl/cpr_ram.sv
rtl/clock_page_replacement_core.sv
test/clock_page_replacement_core_test.sv
